FILE: sv/pcsd_pkg.sv
// ----------------------------------------------------------------------------
// Prefix-coded size decoder package
// Shared constants, payload types and a helper function for the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package pcsd_pkg;

    localparam int MAX_CODES       = 256;
    localparam int NUM_TABLES      = 2;
    localparam int MAX_CODE_LENGTH = 31;
    localparam int NUM_SYMBOLS     = 256;
    localparam int MAX_RESULTS     = 64;

    localparam int IDX_W     = $clog2(MAX_CODES);
    localparam int CNT_W     = IDX_W + 1;
    localparam int TBL_W     = $clog2(NUM_TABLES);
    localparam int MEM_DEPTH = NUM_TABLES * MAX_CODES;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam int ITEM_W    = $clog2(NUM_SYMBOLS) + 1;
    localparam int RES_W     = $clog2(MAX_RESULTS + 1);
    localparam int LEN_W     = 5;
    localparam int SYM_W     = 8;
    localparam int VAL_W     = 31;

    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_BYTE  = 2'd1;

    localparam logic CFG_SIZE_COUNT = 1'b0;
    localparam logic CFG_DIFF_MODE  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_NO_MATCH   = 2'd1,
        STATUS_RANGE      = 2'd2,
        STATUS_BAD_HEADER = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [31:0] size_value;
        logic        last;
        status_t     status;
    } out_item_t;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [SYM_W-1:0] sym;
        logic [VAL_W-1:0] val;
    } code_entry_t;

    function automatic logic [2:0] width_of(input logic [4:0] d);
        logic [2:0] w;
        w = 3'd0;
        for (int b = 0; b < 5; b++)
        begin
            if (d[b])
            begin
                w = 3'(b + 1);
            end
        end
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: sv/pcsd_code_ram.sv
// ----------------------------------------------------------------------------
// Code table memory
// Single write port, single registered read port holding both code tables.
// ----------------------------------------------------------------------------
`default_nettype none

module pcsd_code_ram (
    input  wire logic                        clk,
    input  wire logic                        wr_en,
    input  wire logic [pcsd_pkg::MEM_AW-1:0] wr_addr,
    input  wire pcsd_pkg::code_entry_t       wr_data,
    input  wire logic                        rd_en,
    input  wire logic [pcsd_pkg::MEM_AW-1:0] rd_addr,
    output pcsd_pkg::code_entry_t            rd_data
);
    import pcsd_pkg::*;

    code_entry_t mem [MEM_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/prefix_coded_size_decoder.sv
// ----------------------------------------------------------------------------
// Prefix-coded size decoder
// Parses two canonical prefix-code table headers from a byte stream, then
// decodes 7- or 15-bit sizes, plain or as a running sum of signed deltas.
// ----------------------------------------------------------------------------
// A start request arms a run, and the block stays ready after it. Each
// byte or tick request is then worked off by a sequencer around one code
// table memory with a single read and a single write port, and the block
// is not ready until that request is finished. Header fields are shifted
// in bit by bit. Closing a table sorts it by insertion in the memory and
// then numbers the codes. While decoding, every code tried is read from
// memory, takes in the bits its length still needs and is then compared;
// a full result register stalls the sequencer.
`default_nettype none

module prefix_coded_size_decoder (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire pcsd_pkg::in_item_t in_item,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output pcsd_pkg::out_item_t     out_item,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               cfg_index,
    input  wire logic [15:0]        cfg_data
);
    import pcsd_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE, PH_MIN, PH_MAX, PH_SINGLE, PH_MODE, PH_PRESENT, PH_PLEN,
        PH_COUNT, PH_SSYM, PH_SLEN, PH_DEC_LOW, PH_DEC_HIGH
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_RUN, ST_SORT_OUTER, ST_SORT_KEY, ST_SORT_TEST, ST_SORT_CMP,
        ST_NUM_RD, ST_NUM_WR
    } state_t;

    state_t              state_reg, state_next;
    phase_t              phase_reg, phase_next;
    logic [15:0]         size_count_reg, size_count_next;
    logic                diff_mode_reg, diff_mode_next;
    logic [7:0]          bit_buf_reg, bit_buf_next;
    logic [3:0]          bits_left_reg, bits_left_next;
    logic                is_byte_reg, is_byte_next;
    logic [7:0]          in_byte_reg, in_byte_next;
    logic                loaded_reg, loaded_next;
    logic [RES_W-1:0]    res_cnt_reg, res_cnt_next;
    logic [TBL_W-1:0]    hdr_reg, hdr_next;
    logic [7:0]          field_acc_reg, field_acc_next;
    logic [3:0]          field_got_reg, field_got_next;
    logic [ITEM_W-1:0]   item_index_reg, item_index_next;
    logic [4:0]          item_total_reg, item_total_next;
    logic [SYM_W-1:0]    cur_sym_reg, cur_sym_next;
    logic [CNT_W-1:0]    entries_reg [NUM_TABLES];
    logic [CNT_W-1:0]    entries_next [NUM_TABLES];
    logic [SYM_W-1:0]    single_reg [NUM_TABLES];
    logic [SYM_W-1:0]    single_next [NUM_TABLES];
    logic [LEN_W-1:0]    min_reg [NUM_TABLES];
    logic [LEN_W-1:0]    min_next [NUM_TABLES];
    logic [LEN_W-1:0]    max_reg [NUM_TABLES];
    logic [LEN_W-1:0]    max_next [NUM_TABLES];
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [LEN_W-1:0]    nbits_reg, nbits_next;
    logic [VAL_W-1:0]    value_reg, value_next;
    logic                ent_ok_reg, ent_ok_next;
    logic [SYM_W-1:0]    hold_reg, hold_next;
    logic [31:0]         running_reg, running_next;
    logic [15:0]         sizes_done_reg, sizes_done_next;
    logic [CNT_W-1:0]    i_reg, i_next;
    logic [CNT_W-1:0]    j_reg, j_next;
    code_entry_t         key_reg, key_next;
    logic [LEN_W-1:0]    cur_len_reg, cur_len_next;
    logic [31:0]         cur_val_reg, cur_val_next;
    logic                out_valid_reg, out_valid_next;
    out_item_t           out_reg, out_next;

    logic                mem_we;
    logic [MEM_AW-1:0]   mem_waddr;
    code_entry_t         mem_wdata;
    logic                mem_re;
    logic [MEM_AW-1:0]   mem_raddr;
    code_entry_t         mem_rdata;

    pcsd_code_ram u_ram (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    logic              emit_ok;
    logic              is_dec;
    logic [TBL_W-1:0]  dec_t;
    logic [CNT_W-1:0]  dec_n;
    logic [LEN_W-1:0]  mn;
    logic [LEN_W-1:0]  mx;
    logic [3:0]        fwidth;
    logic [7:0]        fv;
    logic [5:0]        add_len;
    logic              add_bad;
    logic              hdr_fail;
    logic [SYM_W-1:0]  g_sym;
    logic              g_low;
    logic              g_chain;
    logic [33:0]       g_delta;
    logic [33:0]       g_sum;
    logic              g_range_bad;
    logic [31:0]       g_raw;
    logic [31:0]       g_size;
    logic [15:0]       g_done;
    logic              g_last;
    logic              have_bit;
    logic              fin_codes;
    logic              fin_table;
    logic              need_bit;
    logic              end_step;
    logic              do_emit;
    out_item_t         emit_item;
    logic              feed_val;
    logic [3:0]        bl_m1;
    logic [CNT_W-1:0]  j_m1;
    logic [CNT_W-1:0]  i_m1;
    logic [31:0]       num_sh;
    logic              sort_after;

    always_comb
    begin
        emit_ok  = !out_valid_reg || out_ready;
        is_dec   = (phase_reg == PH_DEC_LOW) || (phase_reg == PH_DEC_HIGH);
        dec_t    = TBL_W'(phase_reg == PH_DEC_HIGH);
        dec_n    = entries_reg[dec_t];
        mn       = min_reg[hdr_reg];
        mx       = max_reg[hdr_reg];
        fv       = field_acc_reg;
        add_len  = fv[5:0] + {1'b0, mn};
        add_bad  = (entries_reg[hdr_reg] >= CNT_W'(MAX_CODES))
                   || (add_len > 6'(MAX_CODE_LENGTH));
        hdr_fail = ((phase_reg == PH_MAX) && !((mn == 5'd31) && (fv[4:0] == 5'd31))
                    && !((mn == 5'd0) && (fv[4:0] == 5'd0)) && (fv[4:0] < mn))
                   || (((phase_reg == PH_PLEN) || (phase_reg == PH_SLEN)) && add_bad);

        unique case (phase_reg)
            PH_MIN, PH_MAX, PH_COUNT: fwidth = 4'd5;
            PH_SINGLE, PH_SSYM:       fwidth = 4'd8;
            PH_MODE, PH_PRESENT:      fwidth = 4'd1;
            default:                  fwidth = {1'b0, width_of(mx - mn)};
        endcase

        g_sym   = (dec_n == '0) ? single_reg[dec_t] : mem_rdata.sym;
        g_low   = (phase_reg == PH_DEC_LOW);
        g_chain = g_low && g_sym[0];
        if (g_low)
        begin
            g_raw   = {25'd0, g_sym[7:1]};
            g_delta = {{27{g_sym[7]}}, g_sym[7:1]};
        end
        else
        begin
            g_raw   = {17'd0, g_sym, hold_reg[7:1]};
            g_delta = {{19{g_sym[7]}}, g_sym, hold_reg[7:1]};
        end
        g_sum       = {2'b00, running_reg} + g_delta;
        g_range_bad = g_sum[33] || g_sum[32];
        g_size      = diff_mode_reg ? g_sum[31:0] : g_raw;
        g_done      = sizes_done_reg + 16'd1;
        g_last      = (g_done >= size_count_reg);

        have_bit   = (bits_left_reg != 4'd0) || (is_byte_reg && !loaded_reg);
        bl_m1      = bits_left_reg - 4'd1;
        j_m1       = j_reg - CNT_W'(1);
        i_m1       = i_reg - CNT_W'(1);
        sort_after = (key_reg.len < mem_rdata.len)
                     || ((key_reg.len == mem_rdata.len) && (key_reg.sym > mem_rdata.sym));
        if (mem_rdata.len < cur_len_reg)
        begin
            num_sh = cur_val_reg >> (cur_len_reg - mem_rdata.len);
        end
        else
        begin
            num_sh = cur_val_reg;
        end

        state_next      = state_reg;
        phase_next      = phase_reg;
        size_count_next = size_count_reg;
        diff_mode_next  = diff_mode_reg;
        bit_buf_next    = bit_buf_reg;
        bits_left_next  = bits_left_reg;
        is_byte_next    = is_byte_reg;
        in_byte_next    = in_byte_reg;
        loaded_next     = loaded_reg;
        res_cnt_next    = res_cnt_reg;
        hdr_next        = hdr_reg;
        field_acc_next  = field_acc_reg;
        field_got_next  = field_got_reg;
        item_index_next = item_index_reg;
        item_total_next = item_total_reg;
        cur_sym_next    = cur_sym_reg;
        entries_next    = entries_reg;
        single_next     = single_reg;
        min_next        = min_reg;
        max_next        = max_reg;
        idx_next        = idx_reg;
        nbits_next      = nbits_reg;
        value_next      = value_reg;
        ent_ok_next     = ent_ok_reg;
        hold_next       = hold_reg;
        running_next    = running_reg;
        sizes_done_next = sizes_done_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        key_next        = key_reg;
        cur_len_next    = cur_len_reg;
        cur_val_next    = cur_val_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_next        = out_reg;

        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = '0;

        fin_codes = 1'b0;
        fin_table = 1'b0;
        need_bit  = 1'b0;
        end_step  = 1'b0;
        do_emit   = 1'b0;
        emit_item = '0;
        feed_val  = 1'b0;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SIZE_COUNT: size_count_next = cfg_data;
                CFG_DIFF_MODE:  diff_mode_next  = cfg_data[0];
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_item.kind == KIND_START)
                    begin
                        bits_left_next = 4'd0;
                        bit_buf_next   = 8'd0;
                        if (size_count_reg == 16'd0)
                        begin
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            hdr_next        = '0;
                            entries_next[0] = '0;
                            single_next[0]  = '0;
                            phase_next      = PH_MIN;
                            field_acc_next  = 8'd0;
                            field_got_next  = 4'd0;
                        end
                    end
                    else
                    begin
                        is_byte_next = (in_item.kind == KIND_BYTE);
                        in_byte_next = in_item.data_byte;
                        loaded_next  = 1'b0;
                        res_cnt_next = '0;
                        state_next   = ST_RUN;
                    end
                end
            end

            ST_RUN:
            begin
                if ((phase_reg == PH_IDLE) || (res_cnt_reg == RES_W'(MAX_RESULTS)))
                begin
                    end_step = 1'b1;
                end
                else if (!is_dec)
                begin
                    if (field_got_reg < fwidth)
                    begin
                        need_bit = 1'b1;
                    end
                    else if (!(hdr_fail && !emit_ok))
                    begin
                        field_acc_next = 8'd0;
                        field_got_next = 4'd0;
                        if (hdr_fail)
                        begin
                            do_emit          = 1'b1;
                            emit_item.last   = 1'b1;
                            emit_item.status = STATUS_BAD_HEADER;
                            phase_next       = PH_IDLE;
                        end
                        else
                        begin
                            case (phase_reg)
                                PH_MIN:
                                begin
                                    min_next[hdr_reg] = fv[4:0];
                                    phase_next        = PH_MAX;
                                end
                                PH_MAX:
                                begin
                                    max_next[hdr_reg] = fv[4:0];
                                    if ((mn == 5'd31) && (fv[4:0] == 5'd31))
                                    begin
                                        fin_table = 1'b1;
                                    end
                                    else if ((mn == 5'd0) && (fv[4:0] == 5'd0))
                                    begin
                                        phase_next = PH_SINGLE;
                                    end
                                    else
                                    begin
                                        phase_next = PH_MODE;
                                    end
                                end
                                PH_SINGLE:
                                begin
                                    single_next[hdr_reg] = fv;
                                    fin_table            = 1'b1;
                                end
                                PH_MODE:
                                begin
                                    item_index_next = '0;
                                    phase_next      = fv[0] ? PH_PRESENT : PH_COUNT;
                                end
                                PH_PRESENT:
                                begin
                                    cur_sym_next = item_index_reg[SYM_W-1:0];
                                    if (fv[0])
                                    begin
                                        phase_next = PH_PLEN;
                                    end
                                    else
                                    begin
                                        item_index_next = item_index_reg + ITEM_W'(1);
                                        if (item_index_next >= ITEM_W'(NUM_SYMBOLS))
                                        begin
                                            fin_codes = 1'b1;
                                        end
                                        else
                                        begin
                                            phase_next = PH_PRESENT;
                                        end
                                    end
                                end
                                PH_COUNT:
                                begin
                                    item_total_next = fv[4:0];
                                    item_index_next = '0;
                                    if (fv[4:0] == 5'd0)
                                    begin
                                        fin_codes = 1'b1;
                                    end
                                    else
                                    begin
                                        phase_next = PH_SSYM;
                                    end
                                end
                                PH_SSYM:
                                begin
                                    cur_sym_next = fv;
                                    phase_next   = PH_SLEN;
                                end
                                PH_PLEN, PH_SLEN:
                                begin
                                    mem_we        = 1'b1;
                                    mem_waddr     = {hdr_reg, entries_reg[hdr_reg][IDX_W-1:0]};
                                    mem_wdata.len = add_len[LEN_W-1:0];
                                    mem_wdata.sym = cur_sym_reg;
                                    entries_next[hdr_reg] = entries_reg[hdr_reg] + CNT_W'(1);
                                    item_index_next = item_index_reg + ITEM_W'(1);
                                    if (phase_reg == PH_PLEN)
                                    begin
                                        if (item_index_next >= ITEM_W'(NUM_SYMBOLS))
                                        begin
                                            fin_codes = 1'b1;
                                        end
                                        else
                                        begin
                                            phase_next = PH_PRESENT;
                                        end
                                    end
                                    else if (item_index_next >= ITEM_W'(item_total_reg))
                                    begin
                                        fin_codes = 1'b1;
                                    end
                                    else
                                    begin
                                        phase_next = PH_SSYM;
                                    end
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                    end
                end
                else
                begin
                    if ((dec_n != '0) && (idx_reg >= dec_n))
                    begin
                        if (emit_ok)
                        begin
                            do_emit          = 1'b1;
                            emit_item.last   = 1'b1;
                            emit_item.status = STATUS_NO_MATCH;
                            phase_next       = PH_IDLE;
                        end
                    end
                    else if ((dec_n != '0) && !ent_ok_reg)
                    begin
                        mem_re      = 1'b1;
                        mem_raddr   = {dec_t, idx_reg[IDX_W-1:0]};
                        ent_ok_next = 1'b1;
                    end
                    else if ((dec_n != '0) && (mem_rdata.len > nbits_reg))
                    begin
                        need_bit = 1'b1;
                    end
                    else if ((dec_n != '0) && (value_reg != mem_rdata.val))
                    begin
                        idx_next    = idx_reg + CNT_W'(1);
                        ent_ok_next = 1'b0;
                    end
                    else if (g_chain || emit_ok)
                    begin
                        idx_next    = '0;
                        nbits_next  = '0;
                        value_next  = '0;
                        ent_ok_next = 1'b0;
                        if (g_chain)
                        begin
                            hold_next  = g_sym;
                            phase_next = PH_DEC_HIGH;
                        end
                        else if (diff_mode_reg && g_range_bad)
                        begin
                            do_emit          = 1'b1;
                            emit_item.last   = 1'b1;
                            emit_item.status = STATUS_RANGE;
                            phase_next       = PH_IDLE;
                        end
                        else
                        begin
                            if (diff_mode_reg)
                            begin
                                running_next = g_sum[31:0];
                            end
                            sizes_done_next      = g_done;
                            do_emit              = 1'b1;
                            emit_item.size_value = g_size;
                            emit_item.last       = g_last;
                            emit_item.status     = STATUS_OK;
                            phase_next           = g_last ? PH_IDLE : PH_DEC_LOW;
                        end
                    end
                end
            end

            ST_SORT_OUTER:
            begin
                if (i_reg >= entries_reg[hdr_reg])
                begin
                    cur_len_next = max_reg[hdr_reg];
                    cur_val_next = 32'd0;
                    i_next       = entries_reg[hdr_reg];
                    state_next   = ST_NUM_RD;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = {hdr_reg, i_reg[IDX_W-1:0]};
                    state_next = ST_SORT_KEY;
                end
            end

            ST_SORT_KEY:
            begin
                key_next   = mem_rdata;
                j_next     = i_reg;
                state_next = ST_SORT_TEST;
            end

            ST_SORT_TEST:
            begin
                if (j_reg == '0)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = {hdr_reg, j_reg[IDX_W-1:0]};
                    mem_wdata  = key_reg;
                    i_next     = i_reg + CNT_W'(1);
                    state_next = ST_SORT_OUTER;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = {hdr_reg, j_m1[IDX_W-1:0]};
                    state_next = ST_SORT_CMP;
                end
            end

            ST_SORT_CMP:
            begin
                mem_we    = 1'b1;
                mem_waddr = {hdr_reg, j_reg[IDX_W-1:0]};
                if (sort_after)
                begin
                    mem_wdata  = mem_rdata;
                    j_next     = j_m1;
                    state_next = ST_SORT_TEST;
                end
                else
                begin
                    mem_wdata  = key_reg;
                    i_next     = i_reg + CNT_W'(1);
                    state_next = ST_SORT_OUTER;
                end
            end

            ST_NUM_RD:
            begin
                if (i_reg == '0)
                begin
                    fin_table  = 1'b1;
                    state_next = ST_RUN;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = {hdr_reg, i_m1[IDX_W-1:0]};
                    state_next = ST_NUM_WR;
                end
            end

            ST_NUM_WR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = {hdr_reg, i_m1[IDX_W-1:0]};
                mem_wdata.len = mem_rdata.len;
                mem_wdata.sym = mem_rdata.sym;
                mem_wdata.val = num_sh[VAL_W-1:0];
                cur_val_next  = num_sh + 32'd1;
                if (mem_rdata.len < cur_len_reg)
                begin
                    cur_len_next = mem_rdata.len;
                end
                i_next     = i_m1;
                state_next = ST_NUM_RD;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (need_bit)
        begin
            if (!have_bit)
            begin
                end_step = 1'b1;
            end
            else
            begin
                if (bits_left_reg != 4'd0)
                begin
                    feed_val       = bit_buf_reg[bl_m1[2:0]];
                    bits_left_next = bl_m1;
                end
                else
                begin
                    feed_val       = in_byte_reg[7];
                    bit_buf_next   = in_byte_reg;
                    bits_left_next = 4'd7;
                    loaded_next    = 1'b1;
                end
                if (is_dec)
                begin
                    value_next = {value_reg[VAL_W-2:0], feed_val};
                    nbits_next = nbits_reg + LEN_W'(1);
                end
                else
                begin
                    field_acc_next = {field_acc_reg[6:0], feed_val};
                    field_got_next = field_got_reg + 4'd1;
                end
            end
        end

        if (end_step)
        begin
            state_next = ST_IDLE;
            if (phase_reg == PH_IDLE)
            begin
                bits_left_next = 4'd0;
            end
        end

        if (fin_codes)
        begin
            if (entries_next[hdr_reg] != '0)
            begin
                i_next     = CNT_W'(1);
                state_next = ST_SORT_OUTER;
            end
            else
            begin
                fin_table = 1'b1;
            end
        end

        if (fin_table)
        begin
            if (hdr_reg == '0)
            begin
                hdr_next        = TBL_W'(1);
                entries_next[1] = '0;
                single_next[1]  = '0;
                phase_next      = PH_MIN;
                field_acc_next  = 8'd0;
                field_got_next  = 4'd0;
            end
            else
            begin
                sizes_done_next = 16'd0;
                running_next    = 32'd0;
                phase_next      = PH_DEC_LOW;
                idx_next        = '0;
                nbits_next      = '0;
                value_next      = '0;
                ent_ok_next     = 1'b0;
            end
        end

        if (do_emit)
        begin
            out_valid_next = 1'b1;
            out_next       = emit_item;
            res_cnt_next   = res_cnt_reg + RES_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            phase_reg      <= PH_IDLE;
            size_count_reg <= '0;
            diff_mode_reg  <= 1'b0;
            bit_buf_reg    <= '0;
            bits_left_reg  <= '0;
            is_byte_reg    <= 1'b0;
            in_byte_reg    <= '0;
            loaded_reg     <= 1'b0;
            res_cnt_reg    <= '0;
            hdr_reg        <= '0;
            field_acc_reg  <= '0;
            field_got_reg  <= '0;
            item_index_reg <= '0;
            item_total_reg <= '0;
            cur_sym_reg    <= '0;
            for (int t = 0; t < NUM_TABLES; t++)
            begin
                entries_reg[t] <= '0;
                single_reg[t]  <= '0;
                min_reg[t]     <= '0;
                max_reg[t]     <= '0;
            end
            idx_reg        <= '0;
            nbits_reg      <= '0;
            value_reg      <= '0;
            ent_ok_reg     <= 1'b0;
            hold_reg       <= '0;
            running_reg    <= '0;
            sizes_done_reg <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            key_reg        <= '0;
            cur_len_reg    <= '0;
            cur_val_reg    <= '0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            size_count_reg <= size_count_next;
            diff_mode_reg  <= diff_mode_next;
            bit_buf_reg    <= bit_buf_next;
            bits_left_reg  <= bits_left_next;
            is_byte_reg    <= is_byte_next;
            in_byte_reg    <= in_byte_next;
            loaded_reg     <= loaded_next;
            res_cnt_reg    <= res_cnt_next;
            hdr_reg        <= hdr_next;
            field_acc_reg  <= field_acc_next;
            field_got_reg  <= field_got_next;
            item_index_reg <= item_index_next;
            item_total_reg <= item_total_next;
            cur_sym_reg    <= cur_sym_next;
            entries_reg    <= entries_next;
            single_reg     <= single_next;
            min_reg        <= min_next;
            max_reg        <= max_next;
            idx_reg        <= idx_next;
            nbits_reg      <= nbits_next;
            value_reg      <= value_next;
            ent_ok_reg     <= ent_ok_next;
            hold_reg       <= hold_next;
            running_reg    <= running_next;
            sizes_done_reg <= sizes_done_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            key_reg        <= key_next;
            cur_len_reg    <= cur_len_next;
            cur_val_reg    <= cur_val_next;
            out_valid_reg  <= out_valid_next;
            out_reg        <= out_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/pcsd_checker.sv
// ----------------------------------------------------------------------------
// Prefix-coded size decoder checker
// Port-level assertions on result encoding and request timing.
// ----------------------------------------------------------------------------
`default_nettype none

module pcsd_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_ready,
    input wire pcsd_pkg::in_item_t  in_item,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire pcsd_pkg::out_item_t out_item
);
    import pcsd_pkg::*;

    // An error result always closes the run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_item.status != STATUS_OK)) |-> out_item.last)
        else $error("error result without last");

    // Error results carry a zero size.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_item.status != STATUS_OK)) |-> (out_item.size_value == 32'd0))
        else $error("error result with nonzero size");

    // A start request completes at once, so the block is ready again.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (in_item.kind == KIND_START)) |=> in_ready)
        else $error("not ready after start request");

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_item)))
        else $error("stalled result changed");

endmodule

bind prefix_coded_size_decoder pcsd_checker u_pcsd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);

`default_nettype wire
